// File: hw/rtl/max_heap_priority_queue_core_assert.svh
// assertion macros shared by the heap queue rtl
`ifndef MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MHPQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("heap queue property violated");
`define MHPQ_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("heap queue forbidden condition");
`else
`define MHPQ_ASSERT(lbl, clk, rstn, prop)
`define MHPQ_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hw/rtl/mhpq_pkg.sv
// types and constants of the heap priority queue
package mhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned DATA_W       = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic start_push;
    logic start_pop;
    logic load_last;
    logic up_root;
    logic rd_parent;
    logic up_eval;
    logic dn_place;
    logic rd_left;
    logic rd_right;
    logic dn_eval;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic pos_zero;
    logic has_left;
    logic up_move;
    logic dn_move;
  } dp_stat_t;

endpackage

// File: hw/rtl/mhpq_dpath.sv
// heap datapath: entry memory, count, position, moving value and result word
`include "max_heap_priority_queue_core_assert.svh"

module mhpq_dpath #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mhpq_pkg::dp_cmd_t                   cmd_i,
  output mhpq_pkg::dp_stat_t                  stat_o,
  input  logic signed [mhpq_pkg::DATA_W-1:0]  value_i,
  output logic signed [mhpq_pkg::DATA_W-1:0]  top_value_o,
  output logic        [CW-1:0]                entry_total_o,
  output logic                                is_empty_o
);

  localparam int unsigned DW = mhpq_pkg::DATA_W;

  logic signed [DW-1:0] mem [CAPACITY];

  logic        [CW-1:0] count_q, count_d;
  logic        [AW-1:0] pos_q, pos_d;
  logic signed [DW-1:0] v_q;
  logic signed [DW-1:0] lft_q;
  logic signed [DW-1:0] rd_data_q;
  logic signed [DW-1:0] top_q;
  logic signed [DW-1:0] res_top_q;
  logic        [CW-1:0] res_cnt_q;

  logic        [AW-1:0] parent_idx;
  logic        [AW:0]   left_w;
  logic        [AW:0]   right_w;
  logic        [AW:0]   cnt_ext;
  logic                 has_left;
  logic                 has_right;
  logic                 sel_right;
  logic signed [DW-1:0] child_val;
  logic        [AW-1:0] child_idx;
  logic                 up_move;
  logic                 dn_move;

  logic                 rd_en;
  logic        [AW-1:0] rd_addr;
  logic                 we;
  logic        [AW-1:0] waddr;
  logic signed [DW-1:0] wdata;

  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign left_w     = {pos_q, 1'b1};
  assign right_w    = left_w + (AW+1)'(1);
  assign cnt_ext    = (AW+1)'(count_q);
  assign has_left   = left_w < cnt_ext;
  assign has_right  = right_w < cnt_ext;
  assign sel_right  = has_right && (rd_data_q > lft_q);
  assign child_val  = sel_right ? rd_data_q : lft_q;
  assign child_idx  = sel_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign up_move    = v_q > rd_data_q;
  assign dn_move    = child_val > v_q;

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_full = (count_q == CW'(CAPACITY));
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.has_left   = has_left;
  assign stat_o.up_move    = up_move;
  assign stat_o.dn_move    = dn_move;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.start_pop) begin
      rd_en   = 1'b1;
      rd_addr = AW'(count_q - CW'(1));
    end else if (cmd_i.rd_parent) begin
      rd_en   = 1'b1;
      rd_addr = parent_idx;
    end else if (cmd_i.rd_left) begin
      rd_en   = 1'b1;
      rd_addr = left_w[AW-1:0];
    end else if (cmd_i.rd_right) begin
      rd_en   = 1'b1;
      rd_addr = right_w[AW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = v_q;
    if (cmd_i.up_eval && up_move) begin
      we    = 1'b1;
      wdata = rd_data_q;
    end else if (cmd_i.dn_eval && dn_move) begin
      we    = 1'b1;
      wdata = child_val;
    end else if (cmd_i.up_root || cmd_i.up_eval || cmd_i.dn_place || cmd_i.dn_eval) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    if (cmd_i.start_push) begin
      count_d = count_q + CW'(1);
      pos_d   = AW'(count_q);
    end else if (cmd_i.start_pop) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.load_last) begin
      pos_d   = '0;
    end else if (cmd_i.up_eval && up_move) begin
      pos_d   = parent_idx;
    end else if (cmd_i.dn_eval && dn_move) begin
      pos_d   = child_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_push) begin
      v_q <= value_i;
    end else if (cmd_i.load_last) begin
      v_q <= rd_data_q;
    end
    if (cmd_i.rd_right) begin
      lft_q <= rd_data_q;
    end
    if (we && (waddr == '0)) begin
      top_q <= wdata;
    end
    if (cmd_i.commit) begin
      res_top_q <= (count_q == '0) ? '0 : top_q;
      res_cnt_q <= count_q;
    end
  end

  assign top_value_o   = res_top_q;
  assign entry_total_o = res_cnt_q;
  assign is_empty_o    = (res_cnt_q == '0);

  `MHPQ_NEVER(a_cnt_bound, clk_i, rst_ni, count_q > CW'(CAPACITY))
  `MHPQ_ASSERT(a_wr_in_heap, clk_i, rst_ni, we |-> ((AW+1)'(waddr) < cnt_ext))
  `MHPQ_ASSERT(a_cnt_step, clk_i, rst_ni,
               (count_q != $past(count_q)) |-> $past(cmd_i.start_push || cmd_i.start_pop))

endmodule

// File: hw/rtl/mhpq_ctrl.sv
// heap controller: sequences sift-up and sift-down and owns the handshakes
`include "max_heap_priority_queue_core_assert.svh"

module mhpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output mhpq_pkg::dp_cmd_t    cmd_o,
  input  mhpq_pkg::dp_stat_t   stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_EV,
    S_POP_LD,
    S_DN_RL,
    S_DN_RR,
    S_DN_EV,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  mhpq_pkg::status_e st_q, st_d;
  mhpq_pkg::status_e out_status_q;
  logic              out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (command_i == mhpq_pkg::CMD_PUSH) begin
            if (stat_i.count_full) begin
              st_d    = mhpq_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              cmd_o.start_push = 1'b1;
              st_d    = mhpq_pkg::ST_DONE;
              state_d = S_UP_RD;
            end
          end else begin
            if (stat_i.count_zero) begin
              st_d    = mhpq_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.start_pop = 1'b1;
              st_d    = mhpq_pkg::ST_DONE;
              state_d = S_POP_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.up_root = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d = S_UP_EV;
        end
      end
      S_UP_EV: begin
        cmd_o.up_eval = 1'b1;
        state_d = stat_i.up_move ? S_UP_RD : S_DONE;
      end
      S_POP_LD: begin
        cmd_o.load_last = 1'b1;
        state_d = stat_i.count_zero ? S_DONE : S_DN_RL;
      end
      S_DN_RL: begin
        if (stat_i.has_left) begin
          cmd_o.rd_left = 1'b1;
          state_d = S_DN_RR;
        end else begin
          cmd_o.dn_place = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DN_RR: begin
        cmd_o.rd_right = 1'b1;
        state_d = S_DN_EV;
      end
      S_DN_EV: begin
        cmd_o.dn_eval = 1'b1;
        state_d = stat_i.dn_move ? S_DN_RL : S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      st_q         <= mhpq_pkg::ST_DONE;
      out_valid_q  <= 1'b0;
      out_status_q <= mhpq_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      if (cmd_o.commit) begin
        out_valid_q  <= 1'b1;
        out_status_q <= st_q;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;

  `MHPQ_NEVER(a_no_clobber, clk_i, rst_ni, cmd_o.commit && out_valid_q && out_stall_i)
  `MHPQ_ASSERT(a_valid_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `MHPQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_q && out_stall_i) |=> out_valid_q)

endmodule

// File: hw/rtl/max_heap_priority_queue_core.sv
// top level of the binary max-heap priority queue
//
//   channel   direction   handshake                 word
//   in        sink        in_valid_i / in_stall_o   command_i, value_i
//   out       source      out_valid_o / out_stall_i top_value_o, entry_total_o,
//                                                   is_empty_o, status_o
//
// push: per level it climbs, the parent is read and moved down; then the value is placed at
//   the root, or the parent is read and the value placed below it, and the result is posted
// pop: the last entry is fetched, per level it sinks both children are read and one moves up;
//   then it goes to a leaf, or both children are read and it is placed; the result is posted
// reset clears the entry count and position; the entry memory is not cleared
// a new word is taken while a result waits; a finished item waits for the result register
module max_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic signed [mhpq_pkg::DATA_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [mhpq_pkg::DATA_W-1:0]  top_value_o,
  output logic        [CW-1:0]                entry_total_o,
  output logic                                is_empty_o,
  output logic        [1:0]                   status_o
);

  mhpq_pkg::dp_cmd_t  dp_cmd;
  mhpq_pkg::dp_stat_t dp_stat;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  mhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .value_i       (value_i),
    .top_value_o   (top_value_o),
    .entry_total_o (entry_total_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

// File: tb/sv/max_heap_priority_queue_core_tb.sv
// testbench for the max-heap priority queue core: heap mirror scoreboard and random traffic
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;

  localparam int unsigned CAP           = mhpq_pkg::CAPACITY_DEF;
  localparam int unsigned TOTAL_W       = $clog2(CAP + 1);
  localparam int unsigned RANDOM_WORDS  = 1350;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned MAX_PRINTS    = 40;

  typedef struct {
    logic signed [mhpq_pkg::DATA_W-1:0] top;
    logic [TOTAL_W-1:0]                 total;
    logic                               empty;
    mhpq_pkg::status_e                  status;
  } heap_result_t;

  class heap_tracker;
    logic signed [mhpq_pkg::DATA_W-1:0] slots [CAP];
    int unsigned                        count;
    heap_result_t                       pending [$];
    int unsigned                        mismatches;
    int unsigned                        checked;
    int unsigned                        pushes;
    int unsigned                        pops;
    int unsigned                        full_drops;
    int unsigned                        empty_pops;
    int unsigned                        peak;

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, checked, got, want);
      end
    endtask

    function void note_word(logic cmd, logic signed [mhpq_pkg::DATA_W-1:0] v);
      heap_result_t                       r;
      logic signed [mhpq_pkg::DATA_W-1:0] t;
      int unsigned                        pos;
      int unsigned                        parent;
      int unsigned                        best;
      int unsigned                        left;
      int unsigned                        right;
      r.status = mhpq_pkg::ST_DONE;
      if (cmd == mhpq_pkg::CMD_PUSH) begin
        pushes++;
        if (count >= CAP) begin
          r.status = mhpq_pkg::ST_FULL;
          full_drops++;
        end else begin
          pos = count;
          slots[pos] = v;
          count++;
          while (pos > 0) begin
            parent = (pos - 1) >> 1;
            if (slots[pos] <= slots[parent]) break;
            t = slots[pos];
            slots[pos] = slots[parent];
            slots[parent] = t;
            pos = parent;
          end
        end
      end else begin
        pops++;
        if (count == 0) begin
          r.status = mhpq_pkg::ST_EMPTY;
          empty_pops++;
        end else begin
          count--;
          slots[0] = slots[count];
          pos = 0;
          forever begin
            best = pos;
            left = 2 * pos + 1;
            right = left + 1;
            if (left >= count) break;
            if (slots[best] < slots[left]) best = left;
            if (right < count && slots[best] < slots[right]) best = right;
            if (best == pos) break;
            t = slots[pos];
            slots[pos] = slots[best];
            slots[best] = t;
            pos = best;
          end
        end
      end
      if (count > peak) peak = count;
      r.top = (count == 0) ? '0 : slots[0];
      r.total = TOTAL_W'(count);
      r.empty = (count == 0);
      pending.push_back(r);
    endfunction

    task check_word(logic signed [mhpq_pkg::DATA_W-1:0] got_top,
                    logic [TOTAL_W-1:0] got_total,
                    logic got_empty, logic [1:0] got_status);
      heap_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("word with nothing pending", got_top, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got_top !== want.top) report_mismatch("top_value", got_top, want.top);
      if (got_total !== want.total) report_mismatch("entry_total", got_total, want.total);
      if (got_empty !== want.empty) report_mismatch("is_empty", got_empty, want.empty);
      if (got_status !== want.status) report_mismatch("status", got_status, want.status);
    endtask
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic                                command_i = mhpq_pkg::CMD_PUSH;
  logic signed [mhpq_pkg::DATA_W-1:0]  value_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic signed [mhpq_pkg::DATA_W-1:0]  top_value_o;
  logic [TOTAL_W-1:0]                  entry_total_o;
  logic                                is_empty_o;
  logic [1:0]                          status_o;

  heap_tracker tracker = new;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          tx_calm = 1'b0;

  max_heap_priority_queue_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_value_o   (top_value_o),
    .entry_total_o (entry_total_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (r < 50) return $signed($urandom_range(0, 15)) - 8;
    if (r < 70) return $urandom_range(0, 1000);
    return $urandom;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure, with calm windows
  always @(posedge clk_i) begin : rx_side
    int unsigned g;
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (((cycle_count / 1500) % 4) == 2) begin
      out_stall_i <= 1'b0;
    end else begin
      g = pick_gap();
      out_stall_i <= (g != 0);
      if (g != 0) stall_left <= g - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_word(command_i, value_i);
      if (out_valid_o && !out_stall_i) begin
        tracker.check_word(top_value_o, entry_total_o, is_empty_o, status_o);
      end
    end
  end

  task automatic send_word(input logic cmd, input logic signed [mhpq_pkg::DATA_W-1:0] v,
                           input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned push_pct;
    logic        cmd;
    bit          full_seen;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, extremes, duplicates, drain to empty
    send_word(mhpq_pkg::CMD_POP, 0, 0);
    send_word(mhpq_pkg::CMD_POP, -1, 3);
    send_word(mhpq_pkg::CMD_PUSH, 32'sh7fff_ffff, 0);
    send_word(mhpq_pkg::CMD_PUSH, 32'sh8000_0000, 0);
    send_word(mhpq_pkg::CMD_PUSH, 0, 2);
    send_word(mhpq_pkg::CMD_PUSH, -1, 0);
    send_word(mhpq_pkg::CMD_PUSH, 5, 0);
    send_word(mhpq_pkg::CMD_PUSH, 5, 0);
    send_word(mhpq_pkg::CMD_PUSH, 32'sh8000_0000, 1);
    repeat (8) send_word(mhpq_pkg::CMD_POP, 32'sh7fff_ffff, 0);
    send_word(mhpq_pkg::CMD_PUSH, -1, 0);
    send_word(mhpq_pkg::CMD_PUSH, -1, 0);
    send_word(mhpq_pkg::CMD_PUSH, -2, 0);
    repeat (4) send_word(mhpq_pkg::CMD_POP, 0, 1);
    drain_results();

    sent = 0;
    full_seen = 1'b0;
    while (sent < RANDOM_WORDS || !full_seen) begin
      tx_calm = ((sent / 120) % 4) == 1;
      if (full_seen) push_pct = 50;
      else if (sent < 150) push_pct = 55;
      else push_pct = 95;
      cmd = ($urandom_range(0, 99) < push_pct) ? mhpq_pkg::CMD_PUSH : mhpq_pkg::CMD_POP;
      send_word(cmd, pick_value(), tx_calm ? 0 : pick_gap());
      sent++;
      if (!full_seen && tracker.count == CAP) begin
        full_seen = 1'b1;
        drain_results();
      end
      if (sent == 600) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d pushes (%0d dropped when full), %0d pops (%0d on empty)",
             tracker.pushes, tracker.full_drops, tracker.pops, tracker.empty_pops);
    $display("peak occupancy %0d of %0d, %0d results checked, %0d mismatches",
             tracker.peak, CAP, tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
